// File: rtl/core/lwf_pkg.sv
package lwf_pkg;

  localparam int SCAN_MAX_DEF = 1024;

  localparam int RANGE_W = 16;
  localparam int RATE_W  = 16;
  localparam int SPEED_W = 16;
  localparam int LEN_W   = 11;

  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  typedef enum logic [2:0] {
    REG_WALL_DISTANCE = 3'd0,
    REG_CRUISE_SPEED  = 3'd1,
    REG_P_GAIN        = 3'd2,
    REG_D_GAIN        = 3'd3,
    REG_FOLLOW_SIDE   = 3'd4,
    REG_ANGLE_STEP    = 3'd5,
    REG_SCAN_LENGTH   = 3'd6
  } reg_t;

  typedef struct packed {
    logic [RANGE_W-1:0] wall_distance;
    logic [SPEED_W-1:0] cruise_speed;
    logic [15:0]        p_gain;
    logic [15:0]        d_gain;
    logic               follow_side;
    logic [15:0]        angle_step;
    logic [LEN_W-1:0]   scan_length;
  } cfg_t;

  typedef struct packed {
    logic [RANGE_W-1:0] nearest_range;
    logic [RANGE_W-1:0] center_range;
  } scan_sum_t;

endpackage

// File: rtl/core/lwf_regs.sv
module lwf_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lwf_pkg::APB_AW-1:0] paddr,
  input  logic [lwf_pkg::APB_DW-1:0] pwdata,
  output logic [lwf_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output lwf_pkg::cfg_t              cfg
);
  import lwf_pkg::*;

  logic [2:0] reg_index;
  logic       wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign wr_en     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wall_distance <= 16'd600;
      cfg.cruise_speed  <= 16'd700;
      cfg.p_gain        <= 16'd1280;
      cfg.d_gain        <= 16'd1280;
      cfg.follow_side   <= 1'b0;
      cfg.angle_step    <= 16'd6283;
      cfg.scan_length   <= 11'd1024;
    end else if (wr_en) begin
      case (reg_index)
        REG_WALL_DISTANCE: cfg.wall_distance <= pwdata[RANGE_W-1:0];
        REG_CRUISE_SPEED:  cfg.cruise_speed  <= pwdata[SPEED_W-1:0];
        REG_P_GAIN:        cfg.p_gain        <= pwdata[15:0];
        REG_D_GAIN:        cfg.d_gain        <= pwdata[15:0];
        REG_FOLLOW_SIDE:   cfg.follow_side   <= pwdata[0];
        REG_ANGLE_STEP:    cfg.angle_step    <= pwdata[15:0];
        REG_SCAN_LENGTH:   cfg.scan_length   <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_WALL_DISTANCE: prdata = APB_DW'(cfg.wall_distance);
      REG_CRUISE_SPEED:  prdata = APB_DW'(cfg.cruise_speed);
      REG_P_GAIN:        prdata = APB_DW'(cfg.p_gain);
      REG_D_GAIN:        prdata = APB_DW'(cfg.d_gain);
      REG_FOLLOW_SIDE:   prdata = APB_DW'(cfg.follow_side);
      REG_ANGLE_STEP:    prdata = APB_DW'(cfg.angle_step);
      REG_SCAN_LENGTH:   prdata = APB_DW'(cfg.scan_length);
      default:           prdata = '0;
    endcase
  end

endmodule

// File: rtl/core/lwf_scan.sv
module lwf_scan #(
  parameter int SCAN_MAX = lwf_pkg::SCAN_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lwf_pkg::cfg_t                 cfg,
  input  logic                          range_valid,
  output logic                          range_ready,
  input  logic [lwf_pkg::RANGE_W-1:0]   range_sample,
  input  logic                          busy,
  output logic                          scan_done,
  output lwf_pkg::scan_sum_t            sum,
  output logic signed [$clog2(SCAN_MAX):0] angle_index
);
  import lwf_pkg::*;

  localparam int IDXW = $clog2(SCAN_MAX);
  localparam int LW   = ($clog2(SCAN_MAX + 1) > LEN_W) ? $clog2(SCAN_MAX + 1) : LEN_W;

  logic [IDXW-1:0]    sample_index;
  logic [IDXW-1:0]    nearest_index;
  logic [RANGE_W-1:0] nearest_range;
  logic [RANGE_W-1:0] center_range;

  logic [LW-1:0] len_raw;
  logic [LW-1:0] len;
  logic [LW-1:0] half;
  logic [LW-1:0] wstart;
  logic [LW-1:0] wend;
  logic [LW-1:0] idx;
  logic [LW-1:0] idx_inc;
  logic          last;
  logic          accept;
  logic          take_first;
  logic          take_less;

  always_comb begin
    len_raw = LW'(cfg.scan_length);
    if (len_raw < LW'(4)) begin
      len = LW'(4);
    end else if (len_raw > LW'(SCAN_MAX)) begin
      len = LW'(SCAN_MAX);
    end else begin
      len = len_raw;
    end
    half       = len >> 1;
    wstart     = cfg.follow_side ? half : '0;
    wend       = cfg.follow_side ? len : half;
    idx        = LW'(sample_index);
    idx_inc    = idx + LW'(1);
    last       = idx_inc >= len;
    take_first = idx == wstart;
    take_less  = (idx > wstart) && (idx < wend) && (range_sample < nearest_range)
                 && (range_sample != '0);
  end

  // hold the last sample of a scan while the previous result is in flight
  assign range_ready = !(last && busy);
  assign accept      = range_valid && range_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index  <= '0;
      nearest_index <= '0;
      nearest_range <= '0;
      center_range  <= '0;
      scan_done     <= 1'b0;
    end else begin
      scan_done <= accept && last;
      if (accept) begin
        if (take_first || take_less) begin
          nearest_range <= range_sample;
          nearest_index <= sample_index;
        end
        if (idx == half) begin
          center_range <= range_sample;
        end
        sample_index <= last ? '0 : idx_inc[IDXW-1:0];
      end
    end
  end

  assign sum.nearest_range = nearest_range;
  assign sum.center_range  = center_range;
  assign angle_index = $signed({1'b0, nearest_index}) - $signed({1'b0, half[IDXW-1:0]});

`ifndef ASSERT_OFF
  a_done_wraps: assert property (@(posedge clk) disable iff (rst)
    scan_done |-> sample_index == '0)
    else $error("scan end did not restart the sample count");

  a_done_isolated: assert property (@(posedge clk) disable iff (rst)
    scan_done |=> !scan_done)
    else $error("scan ended on two successive samples");
`endif

endmodule

// File: rtl/core/lwf_law.sv
module lwf_law #(
  parameter int SCAN_MAX = lwf_pkg::SCAN_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  lwf_pkg::cfg_t                     cfg,
  input  logic                              scan_done,
  input  lwf_pkg::scan_sum_t                sum,
  input  logic signed [$clog2(SCAN_MAX):0]  angle_index,
  output logic                              busy,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic signed [lwf_pkg::RATE_W-1:0] angular_rate,
  output logic [lwf_pkg::SPEED_W-1:0]       linear_speed
);
  import lwf_pkg::*;

  localparam int IDXW  = $clog2(SCAN_MAX);
  localparam int ANG_W = IDXW + 18;
  localparam int SUM_W = (IDXW + 27 > 47) ? IDXW + 27 : 47;
  localparam int XS_W  = SUM_W - 11;

  localparam logic signed [SUM_W-1:0] ANG_BIAS   = SUM_W'(1570796 * 256 + 128000);
  localparam logic signed [SUM_W-1:0] SIDE_LIMIT = SUM_W'(1750000);
  localparam logic signed [XS_W-1:0]  XS_HI      = XS_W'(4095999);
  localparam logic signed [XS_W-1:0]  XS_LO      = -XS_W'(4096000);
  localparam logic [XS_W-1:0]         XS_OFFSET  = XS_W'(4096000);
  localparam logic [22:0]             Y_MAX      = 23'd8191999;
  localparam logic [23:0]             RECIP_125  = 24'd8589935;
  localparam logic [16:0]             RECIP_5    = 17'd104858;

  logic [5:0] vld;
  logic signed [16:0] prev_error;

  logic signed [16:0] err1;
  logic signed [17:0] chg1;

  logic signed [16:0] err2;
  logic signed [17:0] chg2;
  logic signed [IDXW:0] ang2;
  logic lo2, mid2;

  logic signed [33:0] pe3;
  logic signed [34:0] de3;
  logic signed [ANG_W-1:0] ang3;
  logic [SPEED_W-1:0] slow3;
  logic lo3, mid3;
  logic [32:0] slow_prod;

  logic signed [35:0] pdsum;
  logic signed [SUM_W-1:0] ang_ext;
  logic signed [35:0] pd4;
  logic signed [SUM_W-1:0] a4;
  logic [SPEED_W-1:0] speed4;
  logic [SPEED_W-1:0] speed_sel;

  logic signed [SUM_W-1:0] pd_ext;
  logic signed [SUM_W-1:0] x5;
  logic [SPEED_W-1:0] speed5;

  logic signed [XS_W-1:0] xs;
  logic [XS_W-1:0] xs_off;
  logic [22:0] y6;
  logic [SPEED_W-1:0] speed6;

  logic [46:0] prod7;
  logic [SPEED_W-1:0] speed7;

  assign busy = scan_done || (|vld) || result_valid;

  always_comb begin
    err1 = $signed({1'b0, sum.nearest_range}) - $signed({1'b0, cfg.wall_distance});
    chg1 = {err1[16], err1} - {prev_error[16], prev_error};
  end

  always_comb begin
    slow_prod = 33'(cfg.cruise_speed) * 33'(RECIP_5);
    pdsum     = 36'(pe3) + 36'(de3);
    ang_ext   = SUM_W'(ang3);
    if (lo3) begin
      speed_sel = '0;
    end else if (mid3) begin
      speed_sel = cfg.cruise_speed >> 1;
    end else if ((ang_ext > SIDE_LIMIT) || (ang_ext < -SIDE_LIMIT)) begin
      speed_sel = slow3;
    end else begin
      speed_sel = cfg.cruise_speed;
    end
    pd_ext = SUM_W'(pd4);
    xs     = XS_W'(x5 >>> 11);
    xs_off = xs + XS_OFFSET;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld          <= '0;
      prev_error   <= '0;
      result_valid <= 1'b0;
    end else begin
      vld <= {vld[4:0], scan_done};
      if (scan_done) begin
        prev_error <= err1;
      end
      if (vld[5]) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    err2 <= err1;
    chg2 <= chg1;
    ang2 <= angle_index;
    lo2  <= sum.center_range < cfg.wall_distance;
    mid2 <= {1'b0, sum.center_range} < {cfg.wall_distance, 1'b0};

    pe3   <= $signed({1'b0, cfg.p_gain}) * err2;
    de3   <= $signed({1'b0, cfg.d_gain}) * chg2;
    ang3  <= $signed({1'b0, cfg.angle_step}) * ang2;
    slow3 <= {1'b0, slow_prod[32:18]};
    lo3   <= lo2;
    mid3  <= mid2;

    pd4    <= cfg.follow_side ? pdsum : -pdsum;
    a4     <= (ang_ext <<< 8) + ANG_BIAS;
    speed4 <= speed_sel;

    x5     <= (pd_ext <<< 10) - (pd_ext <<< 4) - (pd_ext <<< 3) + a4;
    speed5 <= speed4;

    if (xs > XS_HI) begin
      y6 <= Y_MAX;
    end else if (xs < XS_LO) begin
      y6 <= '0;
    end else begin
      y6 <= xs_off[22:0];
    end
    speed6 <= speed5;

    prod7  <= 47'(y6) * 47'(RECIP_125);
    speed7 <= speed6;

    if (vld[5]) begin
      angular_rate <= {~prod7[45], prod7[44:30]};
      linear_speed <= speed7;
    end
  end

`ifndef ASSERT_OFF
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    $onehot0({vld, result_valid}))
    else $error("more than one result in flight");

  a_enter_empty: assert property (@(posedge clk) disable iff (rst)
    scan_done |-> !(|vld) && !result_valid)
    else $error("scan ended while the previous result was pending");

  a_out_from_pipe: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(vld[5]))
    else $error("result shown without leaving the pipeline");
`endif

endmodule

// File: rtl/core/laser_wall_follow_pd.sv
// Channel   Signals                                   Carries
// range     range_valid/range_ready, range_sample     one range sample per request
// result    result_valid/result_ready, angular_rate,  one command per scan
//           linear_speed
// config    psel/penable/pwrite/paddr/pwdata/prdata   register writes and reads
//
// One range sample is taken every cycle while range_ready is high. The last sample
// of a scan reaches a result register through the scan summary register and the
// seven-register PD law pipeline. The last sample of a scan waits while the previous
// scan's result is still in that pipeline or not yet taken, so scans of 9 or more
// samples run at one sample a cycle when results are taken at once.
// Reset is synchronous; it clears the scan state, the error history and all valids.
module laser_wall_follow_pd #(
  parameter int SCAN_MAX = lwf_pkg::SCAN_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              range_valid,
  output logic                              range_ready,
  input  logic [lwf_pkg::RANGE_W-1:0]       range_sample,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic signed [lwf_pkg::RATE_W-1:0] angular_rate,
  output logic [lwf_pkg::SPEED_W-1:0]       linear_speed,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lwf_pkg::APB_AW-1:0]        paddr,
  input  logic [lwf_pkg::APB_DW-1:0]        pwdata,
  output logic [lwf_pkg::APB_DW-1:0]        prdata,
  output logic                              pready
);
  import lwf_pkg::*;

  localparam int IDXW = $clog2(SCAN_MAX);

  cfg_t                cfg;
  scan_sum_t           sum;
  logic                scan_done;
  logic                busy;
  logic signed [IDXW:0] angle_index;

  lwf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lwf_scan #(
    .SCAN_MAX (SCAN_MAX)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .range_valid  (range_valid),
    .range_ready  (range_ready),
    .range_sample (range_sample),
    .busy         (busy),
    .scan_done    (scan_done),
    .sum          (sum),
    .angle_index  (angle_index)
  );

  lwf_law #(
    .SCAN_MAX (SCAN_MAX)
  ) u_law (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .scan_done    (scan_done),
    .sum          (sum),
    .angle_index  (angle_index),
    .busy         (busy),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .angular_rate (angular_rate),
    .linear_speed (linear_speed)
  );

endmodule
